/* src/fdc_pkg.sv */
`timescale 1ns / 1ps
// Package for the frame decoder with CRC-16 check.
// Types, result codes and frame constants shared by all fdc modules; no dependencies.
package fdc_pkg;

    // Frame geometry
    localparam int unsigned MAX_PAYLOAD  = 246;
    localparam int unsigned MAX_FRAME    = 255;
    localparam int unsigned HEADER_BYTES = 7;
    localparam int unsigned MIN_FRAME    = 9;    // header plus two CRC bytes

    // CRC-16, MSB first, no reflection, no final xor
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Header byte positions
    localparam logic [7:0] POS_MAGIC    = 8'd0;
    localparam logic [7:0] POS_VERSION  = 8'd1;
    localparam logic [7:0] POS_SWARM    = 8'd2;
    localparam logic [7:0] POS_SOURCE   = 8'd3;
    localparam logic [7:0] POS_DEST     = 8'd4;
    localparam logic [7:0] POS_SEQUENCE = 8'd5;
    localparam logic [7:0] POS_LENGTH   = 8'd6;

    // Configuration register indexes
    localparam logic [0:0] REG_MAGIC   = 1'b0;
    localparam logic [0:0] REG_VERSION = 1'b1;

    // Result item kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK,
        STATUS_BAD_SIZE,
        STATUS_BAD_MAGIC,
        STATUS_BAD_VERSION,
        STATUS_BAD_LENGTH,
        STATUS_BAD_CRC
    } fdc_status_t;

    // Configuration values seen by the frame logic
    typedef struct packed {
        logic [7:0] magic_byte;
        logic [3:0] protocol_version;
    } fdc_cfg_t;

    // One result item
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        fdc_status_t status;
        logic [3:0]  frame_type;
        logic [7:0]  swarm;
        logic [7:0]  source;
        logic [7:0]  destination;
        logic [7:0]  sequence_res;
        logic [7:0]  payload_length;
    } fdc_item_t;

endpackage

/* src/frame_decoder_crc16_check.sv */
`timescale 1ns / 1ps
// Top level of the frame decoder with CRC-16 check: input stage, frame logic,
// output register and configuration registers. Depends on fdc_pkg and fdc_frame_ctl.
//
// Usage:
//   Input stream s_*: one frame byte per item in s_tdata, s_tlast on the last byte.
//   Output stream m_*: m_tuser = 0 for a forwarded payload byte, 1 for the
//   end-of-frame status item; header fields ride along on both kinds.
//   Config channel cfg_*: index 0 is the magic byte, index 1 the protocol
//   version (low four bits of cfg_data). cfg_ready is always high; write only
//   while no frame byte is in flight.
// Timing:
//   An accepted byte is captured in the input stage register and, unless the
//   pipe stalls, processed into the output register that drives m_tvalid.
//   Absent a stall, one item per cycle is sustained: the byte-wide CRC update
//   and header decode sit in the single logic stage between input and output
//   registers. Only payload bytes and the last byte (status) give a result item.
// Reset and stall:
//   Reset clears frame state (CRC to 0xFFFF), config registers and both
//   stages. While m_tvalid is high and m_tready low the whole pipe holds and
//   s_tready is low; no item is dropped.
module frame_decoder_crc16_check
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        s_tlast,    // frame_end
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [7:0] payload_byte, [15:8] payload_index,
                                    // [18:16] status, [22:19] frame_type,
                                    // [30:23] swarm, [38:31] source,
                                    // [46:39] destination, [54:47] sequence_res,
                                    // [62:55] payload_length, [63] zero
    output logic        m_tuser,    // [0] result_kind
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic               stall;
    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    logic               out_valid_reg;
    fdc_pkg::fdc_item_t out_item_reg;
    fdc_pkg::fdc_cfg_t  cfg_reg;
    logic               res_valid;
    fdc_pkg::fdc_item_t res;
    logic               step_en;

    // Pipe holds while a result waits
    assign stall    = out_valid_reg && !m_tready;
    assign s_tready = !stall;
    assign step_en  = in_valid_reg && !stall;
    assign cfg_ready = 1'b1;

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && !stall)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    fdc_frame_ctl u_frame
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .rx_byte   (in_byte_reg),
        .frame_end (in_last_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (res_valid && !stall)
        begin
            out_item_reg <= res;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fdc_pkg::REG_MAGIC:   cfg_reg.magic_byte       <= cfg_data;
                fdc_pkg::REG_VERSION: cfg_reg.protocol_version <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Output packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_item_reg.result_kind;
    assign m_tdata  = {1'b0,
                       out_item_reg.payload_length,
                       out_item_reg.sequence_res,
                       out_item_reg.destination,
                       out_item_reg.source,
                       out_item_reg.swarm,
                       out_item_reg.frame_type,
                       out_item_reg.status,
                       out_item_reg.payload_index,
                       out_item_reg.payload_byte};

endmodule

/* src/fdc_crc_byte.sv */
`timescale 1ns / 1ps
// One-byte CRC-16 update (poly 0x1021, MSB first), purely combinational.
// Depends on fdc_pkg for the polynomial.
module fdc_crc_byte
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    // Eight bit steps over the byte folded into the high half
    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ fdc_pkg::CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

/* src/fdc_frame_ctl.sv */
`timescale 1ns / 1ps
// Frame state: byte position, running CRC, header fields and the frame verdict.
// Depends on fdc_pkg and fdc_crc_byte.
module fdc_frame_ctl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic [7:0]          rx_byte,
    input  logic                frame_end,
    input  fdc_pkg::fdc_cfg_t   cfg,
    output logic                res_valid,
    output fdc_pkg::fdc_item_t  res
);

    logic [7:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic        magic_good_reg, magic_good_next;
    logic        version_good_reg, version_good_next;
    logic [3:0]  type_reg, type_next;
    logic [7:0]  swarm_reg, swarm_next;
    logic [7:0]  source_reg, source_next;
    logic [7:0]  dest_reg, dest_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;

    logic [15:0] crc_fed;
    logic [8:0]  crc_end;
    logic [8:0]  frame_len;
    logic        in_header;
    logic        in_payload;
    logic [7:0]  pay_idx;
    logic        pay_emit;
    fdc_pkg::fdc_status_t verdict;

    fdc_crc_byte u_crc
    (
        .crc_in  (crc_reg),
        .data    (rx_byte),
        .crc_out (crc_fed)
    );

    // Region decode
    assign crc_end    = 9'(fdc_pkg::HEADER_BYTES) + {1'b0, len_reg};
    assign in_header  = pos_reg < 8'(fdc_pkg::HEADER_BYTES);
    assign in_payload = !in_header && ({1'b0, pos_reg} < crc_end);
    assign pay_idx    = pos_reg - 8'(fdc_pkg::HEADER_BYTES);
    assign pay_emit   = in_payload && !frame_end && (pay_idx < 8'(fdc_pkg::MAX_PAYLOAD));
    assign frame_len  = {1'b0, pos_reg} + 9'd1;

    // Verdict, checks in priority order
    always_comb
    begin
        if (frame_len < 9'(fdc_pkg::MIN_FRAME) || frame_len > 9'(fdc_pkg::MAX_FRAME))
        begin
            verdict = fdc_pkg::STATUS_BAD_SIZE;
        end
        else if (!magic_good_reg)
        begin
            verdict = fdc_pkg::STATUS_BAD_MAGIC;
        end
        else if (!version_good_reg)
        begin
            verdict = fdc_pkg::STATUS_BAD_VERSION;
        end
        else if (len_reg > 8'(fdc_pkg::MAX_PAYLOAD) ||
                 (crc_end + 9'd2) != frame_len)
        begin
            verdict = fdc_pkg::STATUS_BAD_LENGTH;
        end
        else if ({crc_hi_reg, rx_byte} != crc_reg)
        begin
            verdict = fdc_pkg::STATUS_BAD_CRC;
        end
        else
        begin
            verdict = fdc_pkg::STATUS_OK;
        end
    end

    // Header capture and CRC update for this byte
    always_comb
    begin
        crc_next          = crc_reg;
        magic_good_next   = magic_good_reg;
        version_good_next = version_good_reg;
        type_next         = type_reg;
        swarm_next        = swarm_reg;
        source_next       = source_reg;
        dest_next         = dest_reg;
        seq_next          = seq_reg;
        len_next          = len_reg;
        crc_hi_next       = crc_hi_reg;
        if (in_header || in_payload)
        begin
            crc_next = crc_fed;
        end
        else if ({1'b0, pos_reg} == crc_end)
        begin
            crc_hi_next = rx_byte;
        end
        case (pos_reg)
            fdc_pkg::POS_MAGIC:
            begin
                magic_good_next = (rx_byte == cfg.magic_byte);
            end
            fdc_pkg::POS_VERSION:
            begin
                version_good_next = (rx_byte[7:4] == cfg.protocol_version);
                type_next         = rx_byte[3:0];
            end
            fdc_pkg::POS_SWARM:    swarm_next  = rx_byte;
            fdc_pkg::POS_SOURCE:   source_next = rx_byte;
            fdc_pkg::POS_DEST:     dest_next   = rx_byte;
            fdc_pkg::POS_SEQUENCE: seq_next    = rx_byte;
            fdc_pkg::POS_LENGTH:   len_next    = rx_byte;
            default: ;
        endcase
    end

    // Position: saturates at the largest frame size
    always_comb
    begin
        if (pos_reg < 8'(fdc_pkg::MAX_FRAME))
        begin
            pos_next = pos_reg + 8'd1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    // Result item; header fields include this byte's capture
    always_comb
    begin
        res_valid          = step_en && (frame_end || pay_emit);
        res.result_kind    = frame_end ? fdc_pkg::KIND_STATUS : fdc_pkg::KIND_PAYLOAD;
        res.payload_byte   = frame_end ? 8'd0 : rx_byte;
        res.payload_index  = frame_end ? 8'd0 : pay_idx;
        res.status         = frame_end ? verdict : fdc_pkg::STATUS_OK;
        res.frame_type     = type_next;
        res.swarm          = swarm_next;
        res.source         = source_next;
        res.destination    = dest_next;
        res.sequence_res   = seq_next;
        res.payload_length = len_next;
    end

    // Frame state registers; the last byte returns them to reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= '0;
            crc_reg          <= fdc_pkg::CRC_INIT;
            magic_good_reg   <= 1'b0;
            version_good_reg <= 1'b0;
            type_reg         <= '0;
            swarm_reg        <= '0;
            source_reg       <= '0;
            dest_reg         <= '0;
            seq_reg          <= '0;
            len_reg          <= '0;
            crc_hi_reg       <= '0;
        end
        else if (step_en)
        begin
            if (frame_end)
            begin
                pos_reg          <= '0;
                crc_reg          <= fdc_pkg::CRC_INIT;
                magic_good_reg   <= 1'b0;
                version_good_reg <= 1'b0;
                type_reg         <= '0;
                swarm_reg        <= '0;
                source_reg       <= '0;
                dest_reg         <= '0;
                seq_reg          <= '0;
                len_reg          <= '0;
                crc_hi_reg       <= '0;
            end
            else
            begin
                pos_reg          <= pos_next;
                crc_reg          <= crc_next;
                magic_good_reg   <= magic_good_next;
                version_good_reg <= version_good_next;
                type_reg         <= type_next;
                swarm_reg        <= swarm_next;
                source_reg       <= source_next;
                dest_reg         <= dest_next;
                seq_reg          <= seq_next;
                len_reg          <= len_next;
                crc_hi_reg       <= crc_hi_next;
            end
        end
    end

    // Checks
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && frame_end |=> pos_reg == '0 && crc_reg == fdc_pkg::CRC_INIT)
        else $error("frame state not cleared after last byte");

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 8'(fdc_pkg::MAX_FRAME))
        else $error("byte position past maximum frame");

    a_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind == fdc_pkg::KIND_PAYLOAD
            |-> res.payload_index < 8'(fdc_pkg::MAX_PAYLOAD))
        else $error("payload item index out of range");

    a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.result_kind == fdc_pkg::KIND_STATUS &&
            res.status == fdc_pkg::STATUS_OK |-> frame_len == crc_end + 9'd2)
        else $error("good status on a frame of wrong length");

endmodule

/* tb/sv/fdc_frame_checker.sv */
`timescale 1ns / 1ps
// Checker for the frame decoder with CRC-16 check. It watches the input, output and
// config channels, predicts each result item and compares it. Depends on fdc_pkg.
module fdc_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        s_tlast,    // frame_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,    // payload_byte up to payload_length, see the block
    input  logic        m_tuser,    // [0] result_kind
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int unsigned mismatch_count,
    output int unsigned results_due
);

    // Shadow configuration
    logic [7:0]  cfg_magic;
    logic [3:0]  cfg_version;

    // Shadow frame state
    int unsigned frame_pos;
    logic [15:0] crc_acc;
    logic        magic_ok;
    logic        version_ok;
    logic [3:0]  hdr_type;
    logic [7:0]  hdr_swarm;
    logic [7:0]  hdr_src;
    logic [7:0]  hdr_dst;
    logic [7:0]  hdr_seq;
    logic [7:0]  hdr_len;
    logic [7:0]  crc_hi;

    // Result items predicted but not yet seen on the output
    fdc_pkg::fdc_item_t deframed_items[$];

    function automatic logic [15:0] crc16_next(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ fdc_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic void clear_frame();
        frame_pos  = 0;
        crc_acc    = fdc_pkg::CRC_INIT;
        magic_ok   = 1'b0;
        version_ok = 1'b0;
        hdr_type   = '0;
        hdr_swarm  = '0;
        hdr_src    = '0;
        hdr_dst    = '0;
        hdr_seq    = '0;
        hdr_len    = '0;
        crc_hi     = '0;
    endfunction

    // Item carrying the header values held so far
    function automatic fdc_pkg::fdc_item_t header_item(input logic kind,
                                                       input logic [7:0] b,
                                                       input logic [7:0] idx,
                                                       input fdc_pkg::fdc_status_t st);
        fdc_pkg::fdc_item_t it;
        it.result_kind    = kind;
        it.payload_byte   = b;
        it.payload_index  = idx;
        it.status         = st;
        it.frame_type     = hdr_type;
        it.swarm          = hdr_swarm;
        it.source         = hdr_src;
        it.destination    = hdr_dst;
        it.sequence_res   = hdr_seq;
        it.payload_length = hdr_len;
        return it;
    endfunction

    // Advance the frame state by one received byte, queue what it yields
    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        int unsigned crc_end;
        int unsigned n;
        fdc_pkg::fdc_status_t st;
        crc_end = fdc_pkg::HEADER_BYTES + hdr_len;
        if (frame_pos < fdc_pkg::HEADER_BYTES) begin
            case (frame_pos)
                fdc_pkg::POS_MAGIC:    magic_ok = (b == cfg_magic);
                fdc_pkg::POS_VERSION:
                begin
                    version_ok = (b[7:4] == cfg_version);
                    hdr_type   = b[3:0];
                end
                fdc_pkg::POS_SWARM:    hdr_swarm = b;
                fdc_pkg::POS_SOURCE:   hdr_src   = b;
                fdc_pkg::POS_DEST:     hdr_dst   = b;
                fdc_pkg::POS_SEQUENCE: hdr_seq   = b;
                default:               hdr_len   = b;
            endcase
            crc_acc = crc16_next(crc_acc, b);
        end
        else if (frame_pos < crc_end) begin
            crc_acc = crc16_next(crc_acc, b);
            // a payload byte flagged as last is not forwarded
            if (!last && (frame_pos - fdc_pkg::HEADER_BYTES) < fdc_pkg::MAX_PAYLOAD)
                deframed_items.push_back(header_item(fdc_pkg::KIND_PAYLOAD, b,
                                             8'(frame_pos - fdc_pkg::HEADER_BYTES),
                                             fdc_pkg::STATUS_OK));
        end
        else if (frame_pos == crc_end)
            crc_hi = b;

        if (last) begin
            n = frame_pos + 1;
            if (n < fdc_pkg::MIN_FRAME || n > fdc_pkg::MAX_FRAME)
                st = fdc_pkg::STATUS_BAD_SIZE;
            else if (!magic_ok)
                st = fdc_pkg::STATUS_BAD_MAGIC;
            else if (!version_ok)
                st = fdc_pkg::STATUS_BAD_VERSION;
            else if (hdr_len > fdc_pkg::MAX_PAYLOAD ||
                     fdc_pkg::HEADER_BYTES + hdr_len + 2 != n)
                st = fdc_pkg::STATUS_BAD_LENGTH;
            else if ({crc_hi, b} != crc_acc)
                st = fdc_pkg::STATUS_BAD_CRC;
            else
                st = fdc_pkg::STATUS_OK;
            deframed_items.push_back(header_item(fdc_pkg::KIND_STATUS, 8'h00, 8'h00, st));
            clear_frame();
        end
        else if (frame_pos < fdc_pkg::MAX_FRAME)
            frame_pos++;
    endfunction

    function automatic void compare_field(input string what, input logic [7:0] want,
                                          input logic [7:0] seen);
        if (seen !== want) begin
            mismatch_count++;
            $display("%0t ns  %s: expected %0h, got %0h", $time, what, want, seen);
        end
    endfunction

    // Compare on output, update config, predict on input
    always @(posedge clk or negedge rst_n) begin : watch
        fdc_pkg::fdc_item_t want;
        if (!rst_n) begin
            cfg_magic   = '0;
            cfg_version = '0;
            clear_frame();
            deframed_items.delete();
            results_due = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (deframed_items.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns  result item: expected none, got tuser %0b tdata %h",
                             $time, m_tuser, m_tdata);
                end
                else begin
                    want = deframed_items.pop_front();
                    compare_field("result_kind",    8'(want.result_kind),    8'(m_tuser));
                    compare_field("payload_byte",   want.payload_byte,       m_tdata[7:0]);
                    compare_field("payload_index",  want.payload_index,      m_tdata[15:8]);
                    compare_field("status",         8'(want.status),
                                  8'(m_tdata[18:16]));
                    compare_field("frame_type",     8'(want.frame_type),
                                  8'(m_tdata[22:19]));
                    compare_field("swarm",          want.swarm,              m_tdata[30:23]);
                    compare_field("source",         want.source,             m_tdata[38:31]);
                    compare_field("destination",    want.destination,        m_tdata[46:39]);
                    compare_field("sequence_res",   want.sequence_res,       m_tdata[54:47]);
                    compare_field("payload_length", want.payload_length,     m_tdata[62:55]);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == fdc_pkg::REG_MAGIC)
                    cfg_magic = cfg_data;
                else if (cfg_index == fdc_pkg::REG_VERSION)
                    cfg_version = cfg_data[3:0];
            end
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata, s_tlast);
            results_due = deframed_items.size();
        end
    end

endmodule

/* tb/sv/frame_decoder_crc16_check_tb.sv */
`timescale 1ns / 1ps
// Top of the frame decoder testbench: clock, reset, frame stimulus, output
// back-pressure and the verdict. Depends on fdc_pkg, the block and fdc_frame_checker.
module frame_decoder_crc16_check_tb;

    localparam int unsigned ITEM_TARGET      = 1300;
    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned SINK_HOLD_CYCLES = 300;

    typedef enum {
        FR_GOOD,
        FR_BAD_MAGIC,
        FR_BAD_VERSION,
        FR_BAD_CRC,
        FR_EXTRA,
        FR_TRUNC,
        FR_RUNT,
        FR_LONG_DECL,
        FR_OVERSIZE
    } frame_flavor_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;

    int unsigned mismatch_count;
    int unsigned results_due;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent  = 0;

    // Stimulus-side view of the config and of the idling mode
    logic [7:0]  cur_magic    = '0;
    logic [3:0]  cur_version  = '0;
    logic        src_idle_on  = 1'b1;
    logic        sink_idle_on = 1'b1;
    logic        hold_req     = 1'b0;
    logic        hold_taken   = 1'b0;
    int unsigned hold_left    = 0;

    frame_decoder_crc16_check dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fdc_frame_checker u_frame_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result sink: random back-pressure plus one long hold-off on request
    always @(negedge clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = SINK_HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !sink_idle_on || ($urandom_range(99) >= 13);
    end

    // CRC for building frames on the sending side
    function automatic logic [15:0] frame_crc(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ fdc_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

    // One byte on the input stream; each cycle idles with a small chance first
    task automatic push_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while (src_idle_on && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    // Stop sending and wait until every predicted item has come out
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (results_due == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic new_config(input logic [7:0] magic, input logic [3:0] version);
        settle();
        write_reg(fdc_pkg::REG_MAGIC, magic);
        write_reg(fdc_pkg::REG_VERSION, {4'h0, version});
        cur_magic   = magic;
        cur_version = version;
    endtask

    // Build a frame of the given flavor and send it; cut is the byte count
    // for cut-down frames and the padded size for oversize ones
    task automatic send_frame(input frame_flavor_t flavor, input int unsigned len,
                              input int unsigned cut);
        logic [7:0]  frame_q[$];
        logic [15:0] crc;
        logic [7:0]  magic;
        logic [3:0]  version;
        logic [7:0]  flip;
        logic [31:0] rnd;
        rnd     = $urandom;
        flip    = 8'($urandom_range(1, 255));
        magic   = cur_magic;
        version = cur_version;
        if (flavor == FR_BAD_MAGIC)
            magic ^= flip;
        if (flavor == FR_BAD_VERSION)
            version ^= (flip[3:0] == 4'h0) ? 4'h8 : flip[3:0];

        frame_q.push_back(magic);
        frame_q.push_back({version, rnd[3:0]});
        frame_q.push_back(rnd[15:8]);
        frame_q.push_back(rnd[23:16]);
        frame_q.push_back(rnd[31:24]);
        frame_q.push_back(8'($urandom_range(255)));
        frame_q.push_back(len[7:0]);
        for (int i = 0; i < len; i++)
            frame_q.push_back(8'($urandom_range(255)));
        crc = fdc_pkg::CRC_INIT;
        foreach (frame_q[i])
            crc = frame_crc(crc, frame_q[i]);
        frame_q.push_back(crc[15:8]);
        frame_q.push_back(crc[7:0]);

        case (flavor)
            FR_BAD_CRC:
                frame_q[frame_q.size() - 1 - rnd[4]] ^= flip;
            FR_EXTRA:
                repeat ($urandom_range(1, 5)) frame_q.push_back(8'($urandom_range(255)));
            FR_OVERSIZE:
                while (frame_q.size() < cut) frame_q.push_back(8'($urandom_range(255)));
            FR_TRUNC, FR_RUNT, FR_LONG_DECL:
                while (frame_q.size() > cut) void'(frame_q.pop_back());
            default: ;
        endcase

        foreach (frame_q[i])
            push_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        int unsigned frame_no;
        int unsigned r;
        int unsigned len;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: shortest good frame, one-byte frame, payload byte flagged
        // as last, broken CRC
        new_config(8'hFF, 4'hF);
        send_frame(FR_GOOD, 0, 0);
        send_frame(FR_RUNT, 0, 1);
        send_frame(FR_TRUNC, 2, 8);
        send_frame(FR_BAD_CRC, 0, 0);

        frame_no = 0;
        while (bytes_sent < ITEM_TARGET) begin
            if (frame_no == 0)
                new_config(8'h00, 4'h0);
            else if (frame_no % 10 == 0) begin
                r = $urandom_range(99);
                if (r < 20)
                    new_config(8'h00, 4'h0);
                else if (r < 40)
                    new_config(8'hFF, 4'hF);
                else
                    new_config(8'($urandom_range(255)), 4'($urandom_range(15)));
            end

            // long stretch with no idling on either side
            src_idle_on  = !(frame_no >= 30 && frame_no < 45);
            sink_idle_on = src_idle_on;

            len = ($urandom_range(99) < 4) ? $urandom_range(0, fdc_pkg::MAX_PAYLOAD)
                                           : $urandom_range(0, 12);
            case (frame_no)
                3:  send_frame(FR_GOOD, fdc_pkg::MAX_PAYLOAD, 0);
                6:  send_frame(FR_OVERSIZE, 250, $urandom_range(256, 300));
                15:
                begin
                    // sink holds off while this frame keeps coming
                    hold_req = 1'b1;
                    send_frame(FR_GOOD, 40, 0);
                end
                default:
                begin
                    r = $urandom_range(99);
                    if (r < 66)
                        send_frame(FR_GOOD, len, 0);
                    else if (r < 72)
                        send_frame(FR_BAD_MAGIC, len, 0);
                    else if (r < 78)
                        send_frame(FR_BAD_VERSION, len, 0);
                    else if (r < 85)
                        send_frame(FR_BAD_CRC, len, 0);
                    else if (r < 89)
                        send_frame(FR_EXTRA, len, 0);
                    else if (r < 94) begin
                        if (len == 0)
                            len = 1;
                        send_frame(FR_TRUNC, len, $urandom_range(8, 8 + len));
                    end
                    else if (r < 97)
                        send_frame(FR_RUNT, len, $urandom_range(1, 8));
                    else
                        send_frame(FR_LONG_DECL,
                                   $urandom_range(fdc_pkg::MAX_PAYLOAD + 1, 255),
                                   $urandom_range(9, 30));
                end
            endcase
            frame_no++;
        end

        settle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
